[hdl/next_permutation_generator_top_assert.svh]
// Assertion macros used by the datapath of the permutation generator.
`ifndef NEXT_PERMUTATION_GENERATOR_TOP_ASSERT_SVH
`define NEXT_PERMUTATION_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked outside reset.
`define NPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked during reset as well.
`define NPG_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPG_ASSERT(lbl, prop, msg)
`define NPG_ASSERT_NR(lbl, prop, msg)
`endif
`endif

[hdl/npg_pkg.sv]
package npg_pkg;

  localparam int POS_W       = 4;
  localparam int VAL_W       = 16;
  localparam int LEN_W       = 5;
  localparam int MAX_LEN_DEF = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [LEN_W-1:0] SEQ_LEN_RST = 5'd16;

  localparam logic OPC_LOAD    = 1'b0;
  localparam logic OPC_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN_PRIME,
    ST_SCAN,
    ST_FIND,
    ST_SWAP_I,
    ST_REV_CHK,
    ST_REV_RB,
    ST_REV_WA,
    ST_REV_WB,
    ST_EMIT
  } npg_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_SCAN_INIT,
    CMD_SCAN_STEP,
    CMD_PIVOT,
    CMD_EXH,
    CMD_FIND_STEP,
    CMD_SWAP_J,
    CMD_SWAP_I,
    CMD_REV_RA,
    CMD_REV_RB,
    CMD_REV_WA,
    CMD_REV_WB,
    CMD_EMIT_INIT,
    CMD_EMIT
  } npg_cmd_t;

  typedef struct packed {
    logic len_one;    // sequence of one element
    logic desc;       // element read is below the one to its right
    logic ptr_zero;   // scan reached the first element
    logic gt;         // element read is above the pivot
    logic rev_more;   // tail pointers have not met
    logic out_free;   // output register can take a beat
    logic emit_last;  // emit counter on the final element
  } npg_status_t;

endpackage

[hdl/npg_ram.sv]
module npg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/npg_ctrl.sv]
module npg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_opcode,
  output logic                in_tready,
  input  npg_pkg::npg_status_t status,
  output npg_pkg::npg_cmd_t   cmd
);

  npg_pkg::npg_state_t state_r, state_nxt;
  logic accept;

  assign accept = in_tvalid && (state_r == npg_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npg_pkg::ST_IDLE: begin
        if (accept && (in_opcode == npg_pkg::OPC_ADVANCE)) state_nxt = npg_pkg::ST_CHK;
      end
      npg_pkg::ST_CHK: begin
        state_nxt = status.len_one ? npg_pkg::ST_EMIT : npg_pkg::ST_SCAN_PRIME;
      end
      npg_pkg::ST_SCAN_PRIME: state_nxt = npg_pkg::ST_SCAN;
      npg_pkg::ST_SCAN: begin
        priority if (status.desc)     state_nxt = npg_pkg::ST_FIND;
        else if (status.ptr_zero)     state_nxt = npg_pkg::ST_EMIT;
        else                          state_nxt = npg_pkg::ST_SCAN;
      end
      npg_pkg::ST_FIND: begin
        if (status.gt) state_nxt = npg_pkg::ST_SWAP_I;
      end
      npg_pkg::ST_SWAP_I: state_nxt = npg_pkg::ST_REV_CHK;
      npg_pkg::ST_REV_CHK: begin
        state_nxt = status.rev_more ? npg_pkg::ST_REV_RB : npg_pkg::ST_EMIT;
      end
      npg_pkg::ST_REV_RB: state_nxt = npg_pkg::ST_REV_WA;
      npg_pkg::ST_REV_WA: state_nxt = npg_pkg::ST_REV_WB;
      npg_pkg::ST_REV_WB: state_nxt = npg_pkg::ST_REV_CHK;
      npg_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_last) state_nxt = npg_pkg::ST_IDLE;
      end
      default: state_nxt = npg_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = npg_pkg::CMD_NONE;
    unique case (state_r)
      npg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          cmd = (in_opcode == npg_pkg::OPC_LOAD) ? npg_pkg::CMD_LOAD : npg_pkg::CMD_START;
        end
      end
      npg_pkg::ST_CHK: begin
        cmd = status.len_one ? npg_pkg::CMD_EXH : npg_pkg::CMD_SCAN_INIT;
      end
      npg_pkg::ST_SCAN_PRIME: cmd = npg_pkg::CMD_SCAN_STEP;
      npg_pkg::ST_SCAN: begin
        priority if (status.desc)     cmd = npg_pkg::CMD_PIVOT;
        else if (status.ptr_zero)     cmd = npg_pkg::CMD_EXH;
        else                          cmd = npg_pkg::CMD_SCAN_STEP;
      end
      npg_pkg::ST_FIND: begin
        cmd = status.gt ? npg_pkg::CMD_SWAP_J : npg_pkg::CMD_FIND_STEP;
      end
      npg_pkg::ST_SWAP_I: cmd = npg_pkg::CMD_SWAP_I;
      npg_pkg::ST_REV_CHK: begin
        cmd = status.rev_more ? npg_pkg::CMD_REV_RA : npg_pkg::CMD_EMIT_INIT;
      end
      npg_pkg::ST_REV_RB: cmd = npg_pkg::CMD_REV_RB;
      npg_pkg::ST_REV_WA: cmd = npg_pkg::CMD_REV_WA;
      npg_pkg::ST_REV_WB: cmd = npg_pkg::CMD_REV_WB;
      npg_pkg::ST_EMIT: begin
        if (status.out_free) cmd = npg_pkg::CMD_EMIT;
      end
      default: cmd = npg_pkg::CMD_NONE;
    endcase
  end

endmodule

[hdl/npg_datapath.sv]
`include "next_permutation_generator_top_assert.svh"

module npg_datapath #(
  parameter int MAX_LEN = npg_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [npg_pkg::LEN_W-1:0]    cfg_wdata,
  input  logic [npg_pkg::POS_W-1:0]    in_pos,
  input  logic [npg_pkg::VAL_W-1:0]    in_val,
  input  npg_pkg::npg_cmd_t            cmd,
  output npg_pkg::npg_status_t         status,
  input  logic                         out_tready,
  output logic                         out_valid,
  output logic [npg_pkg::POS_W-1:0]    out_pos,
  output logic [npg_pkg::VAL_W-1:0]    out_val,
  output logic                         out_last,
  output logic                         out_exh
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [npg_pkg::LEN_W-1:0] seq_length_r;
  logic [LW-1:0]             n_r;
  logic [AW-1:0]             ptr_r, j_r, i_r, k_r;
  logic signed [npg_pkg::VAL_W-1:0] prev_r, pivot_r, tmp_r;
  logic                      exh_r;
  logic                      out_valid_r, out_last_r, out_exh_r;
  logic [npg_pkg::POS_W-1:0] out_pos_r;
  logic [npg_pkg::VAL_W-1:0] out_val_r;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [npg_pkg::VAL_W-1:0] ram_wdata, rd_data;
  logic signed [npg_pkg::VAL_W-1:0] rd_s;

  logic [31:0]   len_ext, n_clamp, pos_ext, k_ext;
  logic [LW-1:0] nm1_full;
  logic [AW-1:0] nm1, pos_addr, i_inc, k_inc;
  logic          pos_ok;

  npg_ram #(
    .WIDTH(npg_pkg::VAL_W),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign rd_s = $signed(rd_data);

  // Clamp length to 1..MAX_LEN
  assign len_ext  = 32'(seq_length_r);
  assign n_clamp  = (len_ext == 32'd0) ? 32'd1 :
                    (len_ext > 32'(MAX_LEN)) ? 32'(MAX_LEN) : len_ext;
  assign nm1_full = n_r - LW'(1);
  assign nm1      = nm1_full[AW-1:0];

  assign pos_ext  = 32'(in_pos);
  assign pos_addr = pos_ext[AW-1:0];
  assign pos_ok   = pos_ext < 32'(MAX_LEN);
  assign i_inc    = i_r + AW'(1);
  assign k_inc    = k_r + AW'(1);
  assign k_ext    = 32'(k_r);

  assign status.len_one   = (n_r == LW'(1));
  assign status.desc      = (rd_s < prev_r);
  assign status.ptr_zero  = (ptr_r == '0);
  assign status.gt        = (rd_s > pivot_r);
  assign status.rev_more  = (ptr_r < j_r);
  assign status.out_free  = !out_valid_r || out_tready;
  assign status.emit_last = (k_r == nm1);

  // Memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_addr;
    ram_wdata = in_val;
    ram_raddr = k_r;
    unique case (cmd)
      npg_pkg::CMD_LOAD: ram_we = pos_ok;
      npg_pkg::CMD_SCAN_INIT: ram_raddr = nm1;
      npg_pkg::CMD_SCAN_STEP: ram_raddr = ptr_r - AW'(1);
      npg_pkg::CMD_PIVOT: ram_raddr = nm1;
      npg_pkg::CMD_FIND_STEP: ram_raddr = j_r - AW'(1);
      npg_pkg::CMD_SWAP_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = pivot_r;
      end
      npg_pkg::CMD_SWAP_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = tmp_r;
      end
      npg_pkg::CMD_REV_RA: ram_raddr = ptr_r;
      npg_pkg::CMD_REV_RB: ram_raddr = j_r;
      npg_pkg::CMD_REV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = rd_data;
      end
      npg_pkg::CMD_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = tmp_r;
      end
      npg_pkg::CMD_EXH, npg_pkg::CMD_EMIT_INIT: ram_raddr = '0;
      npg_pkg::CMD_EMIT: ram_raddr = k_inc;
      default: ram_raddr = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_length_r <= npg_pkg::SEQ_LEN_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        seq_length_r <= cfg_wdata;
      end
      if (cmd == npg_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      npg_pkg::CMD_START: begin
        n_r   <= n_clamp[LW-1:0];
        exh_r <= 1'b0;
      end
      npg_pkg::CMD_SCAN_INIT: ptr_r <= nm1;
      npg_pkg::CMD_SCAN_STEP: begin
        prev_r <= rd_s;
        ptr_r  <= ptr_r - AW'(1);
      end
      npg_pkg::CMD_PIVOT: begin
        pivot_r <= rd_s;
        i_r     <= ptr_r;
        j_r     <= nm1;
      end
      npg_pkg::CMD_FIND_STEP: j_r <= j_r - AW'(1);
      npg_pkg::CMD_SWAP_J: tmp_r <= rd_s;
      npg_pkg::CMD_SWAP_I: begin
        ptr_r <= i_inc;
        j_r   <= nm1;
      end
      npg_pkg::CMD_REV_RB: tmp_r <= rd_s;
      npg_pkg::CMD_REV_WB: begin
        ptr_r <= ptr_r + AW'(1);
        j_r   <= j_r - AW'(1);
      end
      npg_pkg::CMD_EXH: begin
        exh_r <= 1'b1;
        k_r   <= '0;
      end
      npg_pkg::CMD_EMIT_INIT: k_r <= '0;
      npg_pkg::CMD_EMIT: begin
        k_r        <= k_inc;
        out_pos_r  <= k_ext[npg_pkg::POS_W-1:0];
        out_val_r  <= rd_data;
        out_last_r <= (k_r == nm1);
        out_exh_r  <= exh_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_val   = out_val_r;
  assign out_last  = out_last_r;
  assign out_exh   = out_exh_r;

  `NPG_ASSERT(a_emit_in_range, (cmd == npg_pkg::CMD_EMIT) |-> ({1'b0, k_r} < n_r), "emit past end")
  `NPG_ASSERT(a_rev_order, (cmd == npg_pkg::CMD_REV_RA) |-> (ptr_r < j_r), "reverse pointers crossed")
  `NPG_ASSERT(a_find_bound, (cmd == npg_pkg::CMD_FIND_STEP) |-> ({1'b0, j_r} > ({1'b0, i_r} + 1'b1)), "successor search ran past pivot")
  `NPG_ASSERT_NR(a_rst_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

[hdl/next_permutation_generator_top.sv]
// Channel | Dir | Handshake              | Payload
// cfg     | in  | cfg_we                 | cfg_wdata = seq_length
// in      | in  | in_tvalid / in_tready  | in_tdata, in_tuser = opcode
// out     | out | out_tvalid / out_tready| out_tdata, out_tlast, out_tuser = exhausted
//
// A load writes one element into the store. An advance of length n runs the scan
// for the last ascent, the successor search, the swap of pivot and successor,
// the tail reversal (check, read, write, write per swapped pair) and then n
// beats of output, one per cycle when the sink keeps up.
// The element store has one registered read port and one write port.
// Reset (rst_n low, synchronous) returns seq_length to 16 and drops any held beat;
// the element store is not cleared. A stalled sink holds the emit sequence.

module next_permutation_generator_top #(
  parameter int MAX_LEN = npg_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [npg_pkg::LEN_W-1:0]       cfg_wdata,    // seq_length
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [npg_pkg::IN_TDATA_W-1:0]  in_tdata,     // [3:0] load_position, [19:4] load_value
  input  logic                            in_tuser,     // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [npg_pkg::OUT_TDATA_W-1:0] out_tdata,    // [3:0] out_position, [19:4] out_value
  output logic                            out_tlast,
  output logic                            out_tuser     // exhausted
);

  npg_pkg::npg_cmd_t    cmd;
  npg_pkg::npg_status_t status;
  logic [npg_pkg::POS_W-1:0] out_pos;
  logic [npg_pkg::VAL_W-1:0] out_val;

  // Sequencer: accepts loads and walks scan, search, swap, reverse and emit
  npg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_opcode(in_tuser),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Element store, pointers and the output register
  npg_datapath #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pos    (in_tdata[npg_pkg::POS_W-1:0]),
    .in_val    (in_tdata[npg_pkg::POS_W+npg_pkg::VAL_W-1:npg_pkg::POS_W]),
    .cmd       (cmd),
    .status    (status),
    .out_tready(out_tready),
    .out_valid (out_tvalid),
    .out_pos   (out_pos),
    .out_val   (out_val),
    .out_last  (out_tlast),
    .out_exh   (out_tuser)
  );

  // Pack the beat, zero fill to whole bytes
  assign out_tdata = {{(npg_pkg::OUT_TDATA_W - npg_pkg::POS_W - npg_pkg::VAL_W){1'b0}},
                      out_val, out_pos};

endmodule

[dv/tb_next_permutation_generator_top.sv]
// Testbench for the next-permutation generator.
// Loads build a sequence in the block's element store and advances step it to
// its lexicographic successor. A local copy of the store and of seq_length
// predicts every emitted beat, which is queued at input acceptance and matched
// in order against the output stream.

module tb_next_permutation_generator_top;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  // Settling time before a register write, once every queued beat is out.
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 260;

  // One emitted element as the block should present it.
  typedef struct {
    logic [npg_pkg::POS_W-1:0]        pos;
    logic signed [npg_pkg::VAL_W-1:0] value;
    logic                             last;
    logic                             exhausted;
  } perm_beat_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [npg_pkg::LEN_W-1:0]       cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [npg_pkg::IN_TDATA_W-1:0]  in_tdata;   // [3:0] load_position, [19:4] load_value
  logic                            in_tuser;   // opcode
  logic                            out_tvalid;
  logic                            out_tready;
  logic [npg_pkg::OUT_TDATA_W-1:0] out_tdata;  // [3:0] out_position, [19:4] out_value
  logic                            out_tlast;
  logic                            out_tuser;  // exhausted

  // Shadow of the block: element store and the length register.
  logic signed [npg_pkg::VAL_W-1:0] shadow_store [npg_pkg::MAX_LEN_DEF];
  logic [npg_pkg::LEN_W-1:0]        shadow_length;

  perm_beat_t pending_beats [$];
  int         error_count;
  int         cycle_count;
  int         items_sent;
  bit         no_idle;  // set for stretches without gaps on either side

  next_permutation_generator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hold the run to a generous cycle budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Element values: a narrow range to force repeats, the full range, or the
  // extremes of the field, minus one and zero.
  function automatic logic signed [npg_pkg::VAL_W-1:0] draw_element(input int style);
    int v;
    case (style)
      0: v = int'($urandom_range(0, 4)) - 2;
      1: v = int'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v[npg_pkg::VAL_W-1:0];
  endfunction

  function automatic int effective_length(input logic [npg_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > npg_pkg::MAX_LEN_DEF) return npg_pkg::MAX_LEN_DEF;
    return int'(len);
  endfunction

  // Step the first n shadow elements to their successor in place; return 0
  // and leave them untouched when the sequence is already the last one.
  function automatic bit successor_in_place(input int n);
    int i;
    int j;
    logic signed [npg_pkg::VAL_W-1:0] t;
    if (n <= 1) return 1'b0;
    i = n - 2;
    while (shadow_store[i] >= shadow_store[i+1]) begin
      if (i == 0) return 1'b0;
      i--;
    end
    j = n - 1;
    while (shadow_store[i] >= shadow_store[j]) j--;
    t = shadow_store[i];
    shadow_store[i] = shadow_store[j];
    shadow_store[j] = t;
    for (int a = i + 1, b = n - 1; a < b; a++, b--) begin
      t = shadow_store[a];
      shadow_store[a] = shadow_store[b];
      shadow_store[b] = t;
    end
    return 1'b1;
  endfunction

  // Apply one accepted beat to the shadow and queue the beats it must emit.
  function automatic void predict_permutation(input logic opcode,
                                              input logic [npg_pkg::POS_W-1:0] pos,
                                              input logic signed [npg_pkg::VAL_W-1:0] value);
    int n;
    bit exhausted;
    perm_beat_t beat;
    if (opcode == npg_pkg::OPC_LOAD) begin
      shadow_store[pos] = value;
    end else begin
      n = effective_length(shadow_length);
      exhausted = !successor_in_place(n);
      for (int k = 0; k < n; k++) begin
        beat.pos       = k[npg_pkg::POS_W-1:0];
        beat.value     = shadow_store[k];
        beat.last      = (k == n - 1);
        beat.exhausted = exhausted;
        pending_beats.push_back(beat);
      end
    end
  endfunction

  // Offer one beat, wait for the handshake, predict, then idle for a while.
  // Valid stays high when no gap follows, so back-to-back beats get through.
  task automatic send_beat(input logic opcode, input logic [npg_pkg::POS_W-1:0] pos,
                           input logic signed [npg_pkg::VAL_W-1:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= opcode;
    in_tdata  <= {{(npg_pkg::IN_TDATA_W-npg_pkg::POS_W-npg_pkg::VAL_W){1'b0}}, value, pos};
    do @(posedge clk); while (!in_tready);
    predict_permutation(opcode, pos, value);
    items_sent++;
    gap = no_idle ? 0 : draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [npg_pkg::POS_W-1:0] pos,
                           input logic signed [npg_pkg::VAL_W-1:0] value);
    send_beat(npg_pkg::OPC_LOAD, pos, value);
  endtask

  // Position and value are don't-care on an advance: drive random bits there.
  task automatic send_advance();
    send_beat(npg_pkg::OPC_ADVANCE, npg_pkg::POS_W'($urandom_range(0, 15)),
              npg_pkg::VAL_W'($urandom_range(0, 65535)));
  endtask

  // Drop valid, let every queued beat out and let the block settle.
  task automatic wait_drained(input int settle);
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write seq_length only with the block idle.
  task automatic write_length(input logic [npg_pkg::LEN_W-1:0] len);
    wait_drained(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    shadow_length = len;
    cfg_we    <= 1'b0;
  endtask

  // Fill the whole store (ascending, repeats and both extremes) and advance
  // once at the reset length of sixteen.
  task automatic test_reset_length();
    logic signed [npg_pkg::VAL_W-1:0] fill [npg_pkg::MAX_LEN_DEF] = '{
      -16'sd32768, -16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd5, 16'sd5, 16'sd100,
      16'sd255, 16'sd256, 16'sd1000, 16'sd4096, 16'sd16384, 16'sd30000,
      16'sd32767, 16'sd32767};
    for (int p = 0; p < npg_pkg::MAX_LEN_DEF; p++) send_load(p[npg_pkg::POS_W-1:0], fill[p]);
    send_advance();
  endtask

  // A length of one has no successor; a length of zero behaves as one.
  task automatic test_single_element();
    write_length(5'd1);
    send_advance();
    write_length(5'd0);
    send_advance();
  endtask

  // Lengths above the store size clamp to sixteen.
  task automatic test_length_clamp();
    write_length(5'd31);
    send_advance();
  endtask

  // A non-increasing sequence is the last permutation: emitted unchanged and
  // flagged exhausted, and it stays so on the next advance.
  task automatic test_last_permutation();
    write_length(5'd3);
    send_load(4'd0, 16'sd7);
    send_load(4'd1, 16'sd3);
    send_load(4'd2, -16'sd2);
    send_advance();
    send_advance();
  endtask

  // Random phases: set a length, load a sequence, then walk through its
  // permutations, with the odd stray load breaking into the walk.
  task automatic test_random_enumeration();
    int r;
    int n;
    int style;
    int advances;
    logic [npg_pkg::LEN_W-1:0] len;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) len = 5'd0;
      else if (r < 10) len = 5'd1;
      else if (r < 15) len = npg_pkg::LEN_W'($urandom_range(17, 31));
      else if (r < 20) len = 5'd16;
      else len = npg_pkg::LEN_W'($urandom_range(2, 6));
      no_idle = 1'b0;
      write_length(len);
      no_idle = ($urandom_range(0, 4) == 0);
      n = effective_length(len);
      style = $urandom_range(0, 2);
      for (int p = 0; p < n; p++) send_load(p[npg_pkg::POS_W-1:0], draw_element(style));
      // Stray loads anywhere in the store.
      repeat ($urandom_range(0, 2))
        send_load(npg_pkg::POS_W'($urandom_range(0, 15)), draw_element(1));
      if (n <= 4) advances = $urandom_range(1, 26);
      else if (n <= 6) advances = $urandom_range(3, 12);
      else advances = $urandom_range(1, 3);
      repeat (advances) begin
        if ($urandom_range(0, 99) < 8)
          send_load(npg_pkg::POS_W'($urandom_range(0, n - 1)), draw_element(style));
        send_advance();
      end
    end
    no_idle = 1'b0;
  endtask

  // Sink: hold ready high most of the time, drop it for random stalls.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (draw_gap() + 1) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Match every output beat against the oldest predicted one.
  always @(posedge clk) begin
    perm_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got pos %0d value %0d last %0b exh %0b",
                 $time, out_tdata[3:0], $signed(out_tdata[19:4]), out_tlast, out_tuser);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_tdata[3:0] !== want.pos) begin
          $display("%0t: out_position expected %0d got %0d", $time, want.pos, out_tdata[3:0]);
          error_count++;
        end
        if (out_tdata[19:4] !== want.value) begin
          $display("%0t: out_value at pos %0d expected %0d got %0d", $time, want.pos,
                   want.value, $signed(out_tdata[19:4]));
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: out_tlast at pos %0d expected %0b got %0b", $time, want.pos,
                   want.last, out_tlast);
          error_count++;
        end
        if (out_tuser !== want.exhausted) begin
          $display("%0t: exhausted at pos %0d expected %0b got %0b", $time, want.pos,
                   want.exhausted, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    items_sent    = 0;
    no_idle       = 1'b0;
    shadow_length = npg_pkg::SEQ_LEN_RST;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= npg_pkg::OPC_LOAD;
    in_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_single_element();
    test_length_clamp();
    test_last_permutation();
    test_random_enumeration();

    // Drain, then allow for any beat that should never have come.
    wait_drained(DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
